FILE: src/siq_pkg.sv
// shared types, codes and defaults for the sorted insertion priority queue
package siq_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam int CAP_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   localparam int STATUS_W = 2;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   localparam logic REQ_ENQUEUE = 1'b0;
   localparam logic REQ_DEQUEUE = 1'b1;

   // what every cell does in a cycle
   localparam int OP_W = 2;
   localparam logic [OP_W-1:0] OP_HOLD   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_POP    = 2'd2;

   typedef struct packed {
      logic [2:0]  urgency;
      logic [15:0] tag;
      logic [7:0]  age;
      logic        sex;
      logic        coverage;
   } entry_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      entry_type       new_entry;
   } cell_ctrl_type;

endpackage

FILE: src/siq_cell.sv
// one slot of the sorted chain: holds an entry and trades it with its neighbors
module siq_cell
   import siq_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          occupied,
   input  entry_type     left_entry,
   input  logic          left_ins,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          ins
);

   entry_type entry_ff;
   entry_type entry_in;

   // new entry belongs at or in front of this slot
   assign ins   = !occupied || (entry_ff.urgency < ctrl.new_entry.urgency);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (ins) begin
               // first inserting slot takes the new entry, the rest shift back
               entry_in = left_ins ? left_entry : ctrl.new_entry;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_HOLD: begin
            entry_in = entry_ff;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

FILE: src/sorted_insert_priority_queue.sv
// top level of the sorted insertion priority queue: cell chain, count, response register
//
//  channel  direction  handshake           payload
//  req      in         req_valid/req_stall req_type, urgency, tag, age, sex, coverage
//  rsp      out        rsp_valid/rsp_stall status, removed entry, queue count
//  csr      in         csr_valid/csr_ready capacity limit
//
// one request per cycle while req_stall is low; the response is registered and appears in the cycle after acceptance.
// all cells compare against the new urgency at once and shift in the same cycle.
// reset empties the queue and sets the capacity limit to 16; slot contents stay as they are.
// req_stall rises only while a response is held and rsp_stall is high.
module sorted_insert_priority_queue
   import siq_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
)
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_type,
   input  logic [2:0]          req_urgency_level,
   input  logic [15:0]         req_patient_tag,
   input  logic [7:0]          req_patient_age,
   input  logic                req_patient_sex,
   input  logic                req_coverage_kind,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [STATUS_W-1:0] rsp_status_code,
   output logic                rsp_out_valid,
   output logic [2:0]          rsp_out_urgency,
   output logic [15:0]         rsp_out_tag,
   output logic [7:0]          rsp_out_age,
   output logic                rsp_out_sex,
   output logic                rsp_out_coverage,
   output logic [4:0]          rsp_queue_count,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [CAP_W-1:0]    csr_capacity_limit
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                removed_ff, removed_in;
   entry_type           out_entry_ff, out_entry_in;
   logic [CMP_W-1:0]    out_count_ff, out_count_in;

   entry_type           cell_entry [MAX_ENTRIES];
   logic                cell_ins   [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] occupied;
   cell_ctrl_type       ctrl;

   logic                take;
   logic                enqueue;
   logic                full;
   logic                empty;
   logic [CMP_W-1:0]    count_wide;
   entry_type           req_entry;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign take      = req_valid && !req_stall;
   assign enqueue   = (req_type == REQ_ENQUEUE);

   assign count_wide = CMP_W'(count_ff);
   assign full  = (count_wide >= CMP_W'(cap_ff)) || (count_wide == CMP_W'(MAX_ENTRIES));
   assign empty = (count_ff == '0);

   always_comb begin
      req_entry.urgency  = req_urgency_level;
      req_entry.tag      = req_patient_tag;
      req_entry.age      = req_patient_age;
      req_entry.sex      = req_patient_sex;
      req_entry.coverage = req_coverage_kind;
   end

   always_comb begin
      ctrl.new_entry = req_entry;
      ctrl.op        = OP_HOLD;
      if (take && enqueue && !full) begin
         ctrl.op = OP_INSERT;
      end else if (take && !enqueue && !empty) begin
         ctrl.op = OP_POP;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
         entry_type left_entry;
         logic      left_ins;
         entry_type right_entry;

         assign occupied[gi] = (count_ff > CNT_W'(gi));

         if (gi == 0) begin : g_head
            assign left_entry = req_entry;
            assign left_ins   = 1'b0;
         end else begin : g_body
            assign left_entry = cell_entry[gi-1];
            assign left_ins   = cell_ins[gi-1];
         end

         if (gi == MAX_ENTRIES - 1) begin : g_tail
            assign right_entry = cell_entry[gi];
         end else begin : g_inner
            assign right_entry = cell_entry[gi+1];
         end

         siq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .occupied    (occupied[gi]),
            .left_entry  (left_entry),
            .left_ins    (left_ins),
            .right_entry (right_entry),
            .entry       (cell_entry[gi]),
            .ins         (cell_ins[gi])
         );
      end
   endgenerate

   always_comb begin
      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity_limit;
      end
   end

   always_comb begin
      count_in     = count_ff;
      status_in    = status_ff;
      removed_in   = removed_ff;
      out_entry_in = out_entry_ff;
      out_count_in = out_count_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      if (take) begin
         rsp_valid_in = 1'b1;
         removed_in   = 1'b0;
         out_entry_in = '0;
         if (enqueue) begin
            if (full) begin
               status_in = STATUS_FULL;
            end else begin
               status_in = STATUS_DONE;
               count_in  = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               status_in = STATUS_EMPTY;
            end else begin
               status_in    = STATUS_DONE;
               removed_in   = 1'b1;
               out_entry_in = cell_entry[0];
               count_in     = count_ff - 1'b1;
            end
         end
         out_count_in = CMP_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff    <= status_in;
      removed_ff   <= removed_in;
      out_entry_ff <= out_entry_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status_code  = status_ff;
   assign rsp_out_valid    = removed_ff;
   assign rsp_out_urgency  = out_entry_ff.urgency;
   assign rsp_out_tag      = out_entry_ff.tag;
   assign rsp_out_age      = out_entry_ff.age;
   assign rsp_out_sex      = out_entry_ff.sex;
   assign rsp_out_coverage = out_entry_ff.coverage;
   assign rsp_queue_count  = out_count_ff[4:0];

endmodule
